// File: rtl/dbvp_pkg.sv
// ----------------------------------------------------------------------------
// dbvp_pkg
// Shared constants, power-of-two fraction tables and divider request type.
// ----------------------------------------------------------------------------
package dbvp_pkg;

  localparam int FRACTION_TABLE_BITS = 10;
  localparam int TOP_BITS            = 5;
  localparam int MUL_STAGES          = FRACTION_TABLE_BITS - TOP_BITS;
  localparam int TOP_ENTRIES         = 1 << TOP_BITS;
  localparam int POW_LAT             = MUL_STAGES + 3;

  localparam logic [21:0]        LOG2_10_Q32   = 22'd2377929;
  localparam logic signed [18:0] LIN_SPAN_MAX  = 19'sd2400;
  localparam logic [24:0]        ONE_Q24       = 25'd16777216;
  localparam logic [6:0]         PCT_FULL      = 7'd100;
  localparam logic [17:0]        RANGE_MIN_RST = 18'h3D8F0;
  localparam logic [17:0]        RANGE_MAX_RST = 18'h00000;

  localparam logic REG_IDX_MIN = 1'b0;
  localparam logic REG_IDX_MAX = 1'b1;

  typedef logic [TOP_ENTRIES-1:0][30:0]     top_tab_t;
  typedef logic [FRACTION_TABLE_BITS:1][30:0] root_tab_t;

  typedef enum logic [1:0] {
    OP_ZERO,
    OP_FULL,
    OP_DIV
  } div_op_t;

  typedef struct packed {
    div_op_t     op;
    logic [30:0] dividend;
    logic [24:0] divisor;
  } div_req_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] bit_v;
    logic [63:0] xr;
    r     = '0;
    bit_v = 64'h1 << 62;
    xr    = x;
    while (bit_v > xr) bit_v = bit_v >> 2;
    while (bit_v != 64'h0) begin
      if (xr >= r + bit_v) begin
        xr = xr - (r + bit_v);
        r  = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  // chain of 2^(-1/2^k) in q1.30
  function automatic root_tab_t build_roots();
    root_tab_t   t;
    logic [63:0] prev;
    logic [63:0] r;
    prev = 64'h1 << 29;
    for (int k = 1; k <= FRACTION_TABLE_BITS; k++) begin
      r    = isqrt64(prev << 30);
      t[k] = r[30:0];
      prev = r;
    end
    return t;
  endfunction

  localparam root_tab_t ROOTS = build_roots();

  // partial products over the upper index bits, q1.30
  function automatic top_tab_t build_top();
    top_tab_t    t;
    logic [63:0] v;
    for (int j = 0; j < TOP_ENTRIES; j++) begin
      v = 64'h1 << 30;
      for (int k = 1; k <= TOP_BITS; k++) begin
        if (((j >> (TOP_BITS - k)) & 1) != 0) begin
          v = (v * {33'b0, ROOTS[k]} + (64'h1 << 29)) >> 30;
        end
      end
      t[j] = v[30:0];
    end
    return t;
  endfunction

  localparam top_tab_t TOP_TAB = build_top();

endpackage

// File: rtl/dbvp_pow.sv
// ----------------------------------------------------------------------------
// dbvp_pow
// Pipelined 10^(-depth/6000) in q1.24 by base-2 exponent splitting.
// ----------------------------------------------------------------------------
module dbvp_pow import dbvp_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [17:0] depth_i,
  output logic [24:0] val_o
);

  logic [39:0]           m_r;
  logic [30:0]           v_r   [MUL_STAGES+1];
  logic [7:0]            ip_r  [MUL_STAGES+1];
  logic [MUL_STAGES-1:0] low_r [MUL_STAGES+1];
  logic [30:0]           rnd;
  logic [24:0]           val_nxt;
  logic [24:0]           val_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m_r      <= {22'b0, depth_i} * {18'b0, LOG2_10_Q32};
      v_r[0]   <= TOP_TAB[m_r[31 -: TOP_BITS]];
      ip_r[0]  <= m_r[39:32];
      low_r[0] <= m_r[31-TOP_BITS -: MUL_STAGES];
    end
  end

  // one conditional root factor per stage, lsb-side index bits
  for (genvar s = 0; s < MUL_STAGES; s++) begin : g_mul
    logic [61:0] prod;
    logic [61:0] prod_rnd;
    assign prod     = {31'b0, v_r[s]} * {31'b0, ROOTS[TOP_BITS+1+s]};
    assign prod_rnd = prod + 62'h2000_0000;
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[s+1]   <= low_r[s][MUL_STAGES-1-s] ? prod_rnd[60:30] : v_r[s];
        ip_r[s+1]  <= ip_r[s];
        low_r[s+1] <= low_r[s];
      end
    end
  end

  assign rnd = v_r[MUL_STAGES] + 31'd32;

  always_comb begin
    if (|ip_r[MUL_STAGES][7:5]) begin
      val_nxt = '0;
    end else begin
      val_nxt = rnd[30:6] >> ip_r[MUL_STAGES][4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r <= val_nxt;
    end
  end

  assign val_o = val_r;

endmodule

// File: rtl/dbvp_div.sv
// ----------------------------------------------------------------------------
// dbvp_div
// Saturating restoring divider, one quotient bit per stage, result 0..100.
// ----------------------------------------------------------------------------
module dbvp_div import dbvp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     valid_i,
  input  div_req_t req_i,
  output logic     valid_o,
  output logic [6:0] pct_o
);

  logic        vld_r [8];
  div_op_t     op_r  [8];
  logic [30:0] rem_r [8];
  logic [24:0] dvs_r [8];
  logic [6:0]  q_r   [8];
  logic        sat;
  logic        out_vld_r;
  logic [6:0]  pct_r;
  logic [6:0]  pct_nxt;

  // quotient of 100 or more saturates
  assign sat = {1'b0, req_i.dividend} >= ({7'b0, req_i.divisor} * 32'd100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0]  <= (req_i.op == OP_DIV && sat) ? OP_FULL : req_i.op;
      rem_r[0] <= req_i.dividend;
      dvs_r[0] <= req_i.divisor;
      q_r[0]   <= '0;
    end
  end

  for (genvar s = 0; s < 7; s++) begin : g_bit
    logic [31:0] trial;
    assign trial = {1'b0, rem_r[s]} - ({7'b0, dvs_r[s]} << (6 - s));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        op_r[s+1]  <= op_r[s];
        dvs_r[s+1] <= dvs_r[s];
        rem_r[s+1] <= trial[31] ? rem_r[s] : trial[30:0];
        q_r[s+1]   <= trial[31] ? q_r[s] : (q_r[s] | (7'd1 << (6 - s)));
      end
    end
  end

  always_comb begin
    case (op_r[7])
      OP_ZERO: pct_nxt = '0;
      OP_FULL: pct_nxt = PCT_FULL;
      OP_DIV:  pct_nxt = q_r[7];
      default: pct_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_r[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pct_r <= pct_nxt;
    end
  end

  assign valid_o = out_vld_r;
  assign pct_o   = pct_r;

  a_div_fits: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && op_r[0] == OP_DIV |-> {1'b0, rem_r[0]} < ({7'b0, dvs_r[0]} * 32'd100))
    else $error("divide request not below saturation");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[7] && op_r[7] == OP_DIV |-> rem_r[7] < {6'b0, dvs_r[7]})
    else $error("final remainder not below divisor");

endmodule

// File: rtl/db_to_volume_percent.sv
// ----------------------------------------------------------------------------
// db_to_volume_percent
// Maps a gain in cdB to a volume percent over a configured dB range.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall carry one gain (in_gain_cdb) per request.
// Output channel: out_valid / out_stall carry one percent per input request,
// in order. The range registers sit on the APB-style cfg_ port: range_min at
// byte address 0, range_max at byte address 4; write only while idle.
// Spans up to 24 dB map linearly, wider spans follow the 10^(dB/60) curve.
// A request passes the front end, power pipeline, select and divider in turn.
// Throughput: one request per cycle unless out_stall holds the pipeline, set
// by the fully pipelined power units and the 7-stage quotient divider.
// Reset clears every valid bit and loads range_min = -10000, range_max = 0.
// A stalled result holds the whole pipeline: in_stall rises together with
// out_valid && out_stall, so nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module db_to_volume_percent import dbvp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] in_gain_cdb,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_percent,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [1:0] {
    MODE_ZERO,
    MODE_FULL,
    MODE_LIN,
    MODE_CURVE
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [17:0] num;
    logic [17:0] span;
  } ctl_t;

  logic signed [17:0] range_min_r;
  logic signed [17:0] range_max_r;
  logic               en;

  logic               s1_vld_r;
  logic signed [17:0] gain_r;
  logic signed [18:0] span_w;
  logic signed [18:0] num_w;
  logic signed [18:0] depth_w;
  ctl_t               ctl_nxt;

  logic               s2_vld_r;
  ctl_t               ctl_r;
  logic [17:0]        depth_r;

  logic               vld_pipe_r [POW_LAT];
  ctl_t               ctl_pipe_r [POW_LAT];
  logic [24:0]        pow_n;
  logic [24:0]        pow_min;

  logic [24:0]        diff;
  logic [24:0]        den;
  ctl_t               ctl_sel;
  div_req_t           req_nxt;
  logic               sel_vld_r;
  div_req_t           req_r;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // configuration port
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= RANGE_MIN_RST;
      range_max_r <= RANGE_MAX_RST;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_IDX_MIN: range_min_r <= cfg_pwdata[17:0];
        REG_IDX_MAX: range_max_r <= cfg_pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_IDX_MIN: cfg_prdata = 32'(range_min_r);
      REG_IDX_MAX: cfg_prdata = 32'(range_max_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // stage 1: capture request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gain_r <= in_gain_cdb;
    end
  end

  // stage 2: classify the range
  assign span_w  = 19'(range_max_r) - 19'(range_min_r);
  assign num_w   = 19'(gain_r) - 19'(range_min_r);
  assign depth_w = 19'(range_max_r) - 19'(gain_r);

  always_comb begin
    ctl_nxt.num  = num_w[17:0];
    ctl_nxt.span = span_w[17:0];
    if (span_w <= 19'sd0) begin
      ctl_nxt.mode = MODE_ZERO;
    end else if (span_w <= LIN_SPAN_MAX) begin
      ctl_nxt.mode = (num_w > 19'sd0) ? MODE_LIN : MODE_ZERO;
    end else if (gain_r >= range_max_r) begin
      ctl_nxt.mode = MODE_FULL;
    end else begin
      ctl_nxt.mode = MODE_CURVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r   <= ctl_nxt;
      depth_r <= depth_w[17:0];
    end
  end

  // curve at the gain and at the range minimum
  dbvp_pow u_pow_gain (
    .clk     (clk),
    .en      (en),
    .depth_i (depth_r),
    .val_o   (pow_n)
  );

  dbvp_pow u_pow_min (
    .clk     (clk),
    .en      (en),
    .depth_i (ctl_r.span),
    .val_o   (pow_min)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < POW_LAT; i++) vld_pipe_r[i] <= 1'b0;
    end else if (en) begin
      vld_pipe_r[0] <= s2_vld_r;
      for (int i = 1; i < POW_LAT; i++) vld_pipe_r[i] <= vld_pipe_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_pipe_r[0] <= ctl_r;
      for (int i = 1; i < POW_LAT; i++) ctl_pipe_r[i] <= ctl_pipe_r[i-1];
    end
  end

  // select stage: build the divide request
  assign ctl_sel = ctl_pipe_r[POW_LAT-1];
  assign diff    = pow_n - pow_min;
  assign den     = ONE_Q24 - pow_min;

  always_comb begin
    req_nxt.op       = OP_ZERO;
    req_nxt.dividend = '0;
    req_nxt.divisor  = '0;
    case (ctl_sel.mode)
      MODE_ZERO: req_nxt.op = OP_ZERO;
      MODE_FULL: req_nxt.op = OP_FULL;
      MODE_LIN: begin
        req_nxt.op       = OP_DIV;
        req_nxt.dividend = 31'(ctl_sel.num) * 31'd200 + 31'(ctl_sel.span);
        req_nxt.divisor  = 25'(ctl_sel.span) << 1;
      end
      MODE_CURVE: begin
        req_nxt.op       = (pow_n > pow_min) ? OP_DIV : OP_ZERO;
        req_nxt.dividend = 31'(diff) * 31'd100 + 31'(den >> 1);
        req_nxt.divisor  = den;
      end
      default: req_nxt.op = OP_ZERO;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_vld_r <= 1'b0;
    end else if (en) begin
      sel_vld_r <= vld_pipe_r[POW_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r <= req_nxt;
    end
  end

  dbvp_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (sel_vld_r),
    .req_i   (req_r),
    .valid_o (out_valid),
    .pct_o   (out_percent)
  );

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_percent <= PCT_FULL)
    else $error("percent above full scale");

  a_pow_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_pipe_r[POW_LAT-1] |-> pow_n <= ONE_Q24 && pow_min <= ONE_Q24)
    else $error("power value above one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_percent))
    else $error("stalled percent changed");

endmodule
